// File: hw/rtl/csma_pkg.sv
// Shared types and constants of the CSMA/CD station MAC.
// Used by every module under hw/rtl and by the port checker.
package csma_pkg;

  // Configuration field widths and register file layout
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned TICKS_W    = 24;
  localparam int unsigned UNIT_W     = 27;
  localparam int unsigned PROB_W     = 17;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 27;

  // Item field widths
  localparam int unsigned MED_W   = 2;
  localparam int unsigned ATT_W   = 4;
  localparam int unsigned STATE_W = 3;

  // Transmit probability is a fraction of 2^16
  localparam int unsigned PROB_FRAC_BITS = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE      = 3'd0,
    CFG_SENSE     = 3'd1,
    CFG_FRAME     = 3'd2,
    CFG_JAM       = 3'd3,
    CFG_SLOT      = 3'd4,
    CFG_BUSY_UNIT = 3'd5,
    CFG_PROB      = 3'd6
  } cfg_idx_e;

  // Register reset values
  localparam logic [MODE_W-1:0]  RST_MODE      = 2'd0;
  localparam logic [TICKS_W-1:0] RST_SENSE     = 24'd960;
  localparam logic [TICKS_W-1:0] RST_FRAME     = 24'd12000;
  localparam logic [TICKS_W-1:0] RST_JAM       = 24'd480;
  localparam logic [TICKS_W-1:0] RST_SLOT      = 24'd5120;
  localparam logic [UNIT_W-1:0]  RST_BUSY_UNIT = 27'd100000000;
  localparam logic [PROB_W-1:0]  RST_PROB      = 17'd32768;

  // Persistence modes (the fourth code acts as one-persistent)
  localparam logic [MODE_W-1:0] MODE_ONEP  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_NONP  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PPERS = 2'd2;

  // Medium codes (the fourth code acts as collision)
  localparam logic [MED_W-1:0] MED_FREE = 2'd0;
  localparam logic [MED_W-1:0] MED_BUSY = 2'd1;

  // Sense history bits
  localparam logic [2:0] SEEN_FREE = 3'b001;
  localparam logic [2:0] SEEN_BUSY = 3'b010;
  localparam logic [2:0] SEEN_COLL = 3'b100;

  // Station state codes as reported on the result port
  localparam logic [STATE_W-1:0] SC_IDLE       = 3'd0;
  localparam logic [STATE_W-1:0] SC_SENSE      = 3'd1;
  localparam logic [STATE_W-1:0] SC_BUSY_WAIT  = 3'd2;
  localparam logic [STATE_W-1:0] SC_SLOT_WAIT  = 3'd3;
  localparam logic [STATE_W-1:0] SC_SENSE_SLOT = 3'd4;
  localparam logic [STATE_W-1:0] SC_TX         = 3'd5;
  localparam logic [STATE_W-1:0] SC_JAM        = 3'd6;
  localparam logic [STATE_W-1:0] SC_BACKOFF    = 3'd7;

  typedef enum logic [7:0] {
    S_IDLE       = 8'b0000_0001,
    S_SENSE      = 8'b0000_0010,
    S_BUSY_WAIT  = 8'b0000_0100,
    S_SLOT_WAIT  = 8'b0000_1000,
    S_SENSE_SLOT = 8'b0001_0000,
    S_TX         = 8'b0010_0000,
    S_JAM        = 8'b0100_0000,
    S_BACKOFF    = 8'b1000_0000
  } state_e;

  // Registered item, decoded for the state update
  typedef struct packed {
    logic [2:0] seen;
    logic       waiting;
    logic       p_hit;
  } item_t;

  // Which product the wait scaler uses, and its power-of-two exponent
  typedef struct packed {
    logic             use_backoff;
    logic [ATT_W-1:0] exp;
  } scale_req_t;

  function automatic logic [STATE_W-1:0] state_code(input state_e st);
    logic [STATE_W-1:0] code;
    case (st)
      S_IDLE:       code = SC_IDLE;
      S_SENSE:      code = SC_SENSE;
      S_BUSY_WAIT:  code = SC_BUSY_WAIT;
      S_SLOT_WAIT:  code = SC_SLOT_WAIT;
      S_SENSE_SLOT: code = SC_SENSE_SLOT;
      S_TX:         code = SC_TX;
      S_JAM:        code = SC_JAM;
      S_BACKOFF:    code = SC_BACKOFF;
      default:      code = SC_IDLE;
    endcase
    return code;
  endfunction

endpackage

// File: hw/rtl/csma_in_stage.sv
// Input register of the station MAC: decodes the medium code, settles the
// p-persistent draw and forms both random wait products. Uses csma_pkg.
module csma_in_stage import csma_pkg::*; #(
  parameter int unsigned RAND_WIDTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic                         advance_i,
  input  logic [MED_W-1:0]             medium_req_i,
  input  logic                         frame_waiting_i,
  input  logic [RAND_WIDTH-1:0]        random_fraction_i,
  input  logic [UNIT_W-1:0]            busy_unit_i,
  input  logic [TICKS_W-1:0]           slot_ticks_i,
  input  logic [PROB_W-1:0]            prob_i,
  output logic                         valid_o,
  output item_t                        item_o,
  output logic [UNIT_W+RAND_WIDTH-1:0] bw_prod_o,
  output logic [TICKS_W+RAND_WIDTH-1:0] bo_prod_o
);

  localparam int unsigned BWP_W = UNIT_W + RAND_WIDTH;
  localparam int unsigned BOP_W = TICKS_W + RAND_WIDTH;
  localparam int unsigned CMP_W = PROB_W + RAND_WIDTH;

  logic                   valid_q, valid_d;
  item_t                  item_q, item_d;
  logic [BWP_W-1:0]       bw_prod_q;
  logic [BOP_W-1:0]       bo_prod_q;
  logic [CMP_W-1:0]       rf_scaled, prob_scaled;

  // Holding flag: loaded on accept, emptied when the item moves on
  always_comb begin
    valid_d = valid_q;
    if (accept_i) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // p-persistent draw: transmit when U < p
  assign rf_scaled   = CMP_W'({random_fraction_i, {PROB_FRAC_BITS{1'b0}}});
  assign prob_scaled = {prob_i, {RAND_WIDTH{1'b0}}};

  always_comb begin
    case (medium_req_i)
      MED_FREE: item_d.seen = SEEN_FREE;
      MED_BUSY: item_d.seen = SEEN_BUSY;
      default:  item_d.seen = SEEN_COLL;
    endcase
    item_d.waiting = frame_waiting_i;
    item_d.p_hit   = rf_scaled < prob_scaled;
  end

  // Payload: one multiplier per wait kind
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      item_q    <= item_d;
      bw_prod_q <= BWP_W'(busy_unit_i) * BWP_W'(random_fraction_i);
      bo_prod_q <= BOP_W'(slot_ticks_i) * BOP_W'(random_fraction_i);
    end
  end

  assign valid_o   = valid_q;
  assign item_o    = item_q;
  assign bw_prod_o = bw_prod_q;
  assign bo_prod_o = bo_prod_q;

endmodule

// File: hw/rtl/csma_wait_scale.sv
// Random wait scaler: floor(product * 2^exp / 2^RAND_WIDTH), saturated to
// the timer width. Uses csma_pkg for widths and the request struct.
module csma_wait_scale import csma_pkg::*; #(
  parameter int unsigned TIMER_WIDTH = 32,
  parameter int unsigned RAND_WIDTH  = 16
) (
  input  logic [UNIT_W+RAND_WIDTH-1:0]  bw_prod_i,
  input  logic [TICKS_W+RAND_WIDTH-1:0] bo_prod_i,
  input  scale_req_t                    req_i,
  output logic [TIMER_WIDTH-1:0]        wait_o
);

  localparam int unsigned PW  = UNIT_W + RAND_WIDTH;
  localparam int unsigned SHW = PW + (2 ** ATT_W) - 1;
  localparam int unsigned EW  = (SHW > TIMER_WIDTH + RAND_WIDTH) ?
                                SHW : TIMER_WIDTH + RAND_WIDTH;

  logic [PW-1:0] prod;
  logic [EW-1:0] ext_w, sh_w;
  logic          ovf;

  assign prod  = req_i.use_backoff ? PW'(bo_prod_i) : bw_prod_i;
  assign ext_w = EW'(prod) << req_i.exp;
  assign sh_w  = ext_w >> RAND_WIDTH;
  assign ovf   = |sh_w[EW-1:TIMER_WIDTH];
  assign wait_o = ovf ? {TIMER_WIDTH{1'b1}} : sh_w[TIMER_WIDTH-1:0];

endmodule

// File: hw/rtl/csma_fsm.sv
// Station state machine and result register: advances one tick per item.
// Uses csma_pkg; the wait length comes from csma_wait_scale.
module csma_fsm import csma_pkg::*; #(
  parameter int unsigned TIMER_WIDTH  = 32,
  parameter int unsigned MAX_ATTEMPTS = 10
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   advance_i,
  input  item_t                  item_i,
  input  logic [TIMER_WIDTH-1:0] wait_i,
  input  logic [MODE_W-1:0]      mode_i,
  input  logic [TICKS_W-1:0]     sense_ticks_i,
  input  logic [TICKS_W-1:0]     frame_ticks_i,
  input  logic [TICKS_W-1:0]     jam_ticks_i,
  input  logic                   out_stall_i,
  output scale_req_t             scale_req_o,
  output logic                   out_valid_o,
  output logic [STATE_W-1:0]     station_state_o,
  output logic                   on_medium_o,
  output logic                   frame_sent_o,
  output logic                   frame_dropped_o,
  output logic [ATT_W-1:0]       attempt_count_o
);

  localparam int unsigned TW = TIMER_WIDTH;

  state_e             st_q, st_d;
  logic [TW-1:0]      cd_q, cd_d, cd_dec;
  logic [2:0]         seen_q, seen_d, seen_acc;
  logic [TW-1:0]      bl_q, bl_d;
  logic [ATT_W-1:0]   att_q, att_d;
  logic [ATT_W:0]     att_inc;
  logic               cd_zero;
  logic               sent, dropped;
  logic [TW-1:0]      sense_cd, frame_cd, jam_cd, bl_eff, cd_eff;
  logic               out_valid_q;
  logic [STATE_W-1:0] state_q;
  logic               on_medium_q, sent_q, dropped_q;
  logic [ATT_W-1:0]   att_out_q;

  assign sense_cd = TW'(sense_ticks_i);
  assign frame_cd = TW'(frame_ticks_i);
  assign jam_cd   = TW'(jam_ticks_i);

  // Countdown steps down first, then the state acts
  assign cd_dec   = (cd_q != '0) ? cd_q - TW'(1) : cd_q;
  assign cd_zero  = (cd_dec == '0);
  assign seen_acc = seen_q | item_i.seen;
  assign att_inc  = {1'b0, att_q} + (ATT_W+1)'(1);

  // Busy wait scales by the current attempt count, backoff by the next one
  assign scale_req_o.use_backoff = (st_q == S_BACKOFF);
  assign scale_req_o.exp = (st_q == S_BACKOFF) ? att_inc[ATT_W-1:0] : att_q;

  // Backoff: draw a new length when none is running
  always_comb begin
    if (bl_q == '0) begin
      bl_eff = wait_i;
      cd_eff = (wait_i != '0) ? wait_i - TW'(1) : '0;
    end else begin
      bl_eff = bl_q;
      cd_eff = cd_dec;
    end
  end

  // Next state
  always_comb begin
    st_d    = st_q;
    cd_d    = cd_dec;
    seen_d  = seen_q;
    bl_d    = bl_q;
    att_d   = att_q;
    sent    = 1'b0;
    dropped = 1'b0;
    case (st_q)
      S_IDLE: begin
        if (item_i.waiting) begin
          st_d   = S_SENSE;
          cd_d   = sense_cd;
          seen_d = '0;
          bl_d   = '0;
        end
      end
      S_SENSE: begin
        seen_d = seen_acc;
        if (cd_zero) begin
          if (seen_acc == SEEN_FREE) begin
            cd_d = frame_cd;
            if (mode_i == MODE_PPERS && !item_i.p_hit) begin
              st_d = S_SLOT_WAIT;
            end else begin
              st_d = S_TX;
            end
          end else if (mode_i == MODE_NONP || mode_i == MODE_PPERS) begin
            st_d   = S_BUSY_WAIT;
            cd_d   = wait_i;
            seen_d = '0;
          end else begin
            seen_d = '0;
            cd_d   = sense_cd;
          end
        end
      end
      S_BUSY_WAIT, S_SLOT_WAIT: begin
        if (cd_zero) begin
          st_d   = (st_q == S_SLOT_WAIT) ? S_SENSE_SLOT : S_SENSE;
          cd_d   = sense_cd;
          seen_d = '0;
          bl_d   = '0;
        end
      end
      S_SENSE_SLOT: begin
        seen_d = seen_acc;
        if (cd_zero) begin
          if (seen_acc == SEEN_FREE) begin
            cd_d = frame_cd;
            st_d = item_i.p_hit ? S_TX : S_SLOT_WAIT;
          end else begin
            st_d = S_BACKOFF;
            cd_d = TW'(1);
          end
        end
      end
      S_TX: begin
        if (item_i.seen == SEEN_COLL) begin
          st_d = S_JAM;
          cd_d = jam_cd;
          bl_d = '0;
        end else if (cd_zero) begin
          st_d  = S_IDLE;
          att_d = '0;
          sent  = 1'b1;
        end
      end
      S_JAM: begin
        if (cd_zero) begin
          st_d = S_BACKOFF;
          cd_d = TW'(1);
        end
      end
      S_BACKOFF: begin
        if (bl_q == '0 && att_inc > (ATT_W+1)'(MAX_ATTEMPTS)) begin
          // attempt limit exceeded: discard the frame
          st_d    = S_IDLE;
          cd_d    = TW'(1);
          att_d   = '0;
          seen_d  = '0;
          bl_d    = '0;
          dropped = 1'b1;
        end else begin
          if (bl_q == '0) begin
            att_d = att_inc[ATT_W-1:0];
          end
          bl_d = bl_eff;
          cd_d = cd_eff;
          if (bl_eff != '0 && cd_eff == '0) begin
            st_d   = S_SENSE;
            cd_d   = sense_cd;
            seen_d = '0;
            bl_d   = '0;
          end
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  // Station state, updated once per item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      cd_q   <= '0;
      seen_q <= '0;
      bl_q   <= '0;
      att_q  <= '0;
    end else if (advance_i) begin
      st_q   <= st_d;
      cd_q   <= cd_d;
      seen_q <= seen_d;
      bl_q   <= bl_d;
      att_q  <= att_d;
    end
  end

  // Result register: filled on advance, held while stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= advance_i | (out_valid_q & out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      state_q     <= state_code(st_d);
      on_medium_q <= (st_d == S_TX) || (st_d == S_JAM);
      sent_q      <= sent;
      dropped_q   <= dropped;
      att_out_q   <= att_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign station_state_o = state_q;
  assign on_medium_o     = on_medium_q;
  assign frame_sent_o    = sent_q;
  assign frame_dropped_o = dropped_q;
  assign attempt_count_o = att_out_q;

endmodule

// File: hw/rtl/csma_cd_station_mac.sv
// Top level of the CSMA/CD station MAC: configuration registers, handshake
// and the input stage, wait scaler and state machine. Uses csma_pkg.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+----------------------------------
//   in      | input     | in_valid_i/in_stall_o | medium_req, frame_waiting, random
//   out     | output    | out_valid_o/out_stall_i | state, on_medium, sent, dropped,
//           |           |                      | attempt_count
//   cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One item per clock cycle while out_stall_i is low; each item is one station tick.
// An item passes the input register, then the state update into the result
// register. The per-tick state update is the loop of this path.
// Reset puts the station in idle with all timers and counts cleared.
// A stalled result holds the input register; in_stall_o rises only when both
// the input register and the result register are full and out_stall_i is high.
module csma_cd_station_mac import csma_pkg::*; #(
  parameter int unsigned TIMER_WIDTH  = 32,
  parameter int unsigned MAX_ATTEMPTS = 10,
  parameter int unsigned RAND_WIDTH   = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // item input
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [MED_W-1:0]      medium_req_i,
  input  logic                  frame_waiting_i,
  input  logic [RAND_WIDTH-1:0] random_fraction_i,
  // result output
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [STATE_W-1:0]    station_state_o,
  output logic                  on_medium_o,
  output logic                  frame_sent_o,
  output logic                  frame_dropped_o,
  output logic [ATT_W-1:0]      attempt_count_o,
  // configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [MODE_W-1:0]  mode_q;
  logic [TICKS_W-1:0] sense_q, frame_q, jam_q, slot_q;
  logic [UNIT_W-1:0]  busy_unit_q;
  logic [PROB_W-1:0]  prob_q;

  logic                          s1_valid, accept, advance;
  item_t                         s1_item;
  logic [UNIT_W+RAND_WIDTH-1:0]  bw_prod;
  logic [TICKS_W+RAND_WIDTH-1:0] bo_prod;
  scale_req_t                    scale_req;
  logic [TIMER_WIDTH-1:0]        wait_len;

  // Configuration registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= RST_MODE;
      sense_q     <= RST_SENSE;
      frame_q     <= RST_FRAME;
      jam_q       <= RST_JAM;
      slot_q      <= RST_SLOT;
      busy_unit_q <= RST_BUSY_UNIT;
      prob_q      <= RST_PROB;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MODE:      mode_q      <= cfg_data_i[MODE_W-1:0];
        CFG_SENSE:     sense_q     <= cfg_data_i[TICKS_W-1:0];
        CFG_FRAME:     frame_q     <= cfg_data_i[TICKS_W-1:0];
        CFG_JAM:       jam_q       <= cfg_data_i[TICKS_W-1:0];
        CFG_SLOT:      slot_q      <= cfg_data_i[TICKS_W-1:0];
        CFG_BUSY_UNIT: busy_unit_q <= cfg_data_i[UNIT_W-1:0];
        CFG_PROB:      prob_q      <= cfg_data_i[PROB_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: the held item moves on whenever the result register frees up
  assign advance    = s1_valid & (~out_valid_o | ~out_stall_i);
  assign in_stall_o = s1_valid & out_valid_o & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  csma_in_stage #(
    .RAND_WIDTH (RAND_WIDTH)
  ) u_in_stage (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .accept_i          (accept),
    .advance_i         (advance),
    .medium_req_i      (medium_req_i),
    .frame_waiting_i   (frame_waiting_i),
    .random_fraction_i (random_fraction_i),
    .busy_unit_i       (busy_unit_q),
    .slot_ticks_i      (slot_q),
    .prob_i            (prob_q),
    .valid_o           (s1_valid),
    .item_o            (s1_item),
    .bw_prod_o         (bw_prod),
    .bo_prod_o         (bo_prod)
  );

  csma_wait_scale #(
    .TIMER_WIDTH (TIMER_WIDTH),
    .RAND_WIDTH  (RAND_WIDTH)
  ) u_wait_scale (
    .bw_prod_i (bw_prod),
    .bo_prod_i (bo_prod),
    .req_i     (scale_req),
    .wait_o    (wait_len)
  );

  csma_fsm #(
    .TIMER_WIDTH  (TIMER_WIDTH),
    .MAX_ATTEMPTS (MAX_ATTEMPTS)
  ) u_fsm (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .advance_i       (advance),
    .item_i          (s1_item),
    .wait_i          (wait_len),
    .mode_i          (mode_q),
    .sense_ticks_i   (sense_q),
    .frame_ticks_i   (frame_q),
    .jam_ticks_i     (jam_q),
    .out_stall_i     (out_stall_i),
    .scale_req_o     (scale_req),
    .out_valid_o     (out_valid_o),
    .station_state_o (station_state_o),
    .on_medium_o     (on_medium_o),
    .frame_sent_o    (frame_sent_o),
    .frame_dropped_o (frame_dropped_o),
    .attempt_count_o (attempt_count_o)
  );

endmodule

// File: hw/rtl/csma_mac_checker.sv
// Port-level checks of the CSMA/CD station MAC result channel, bound to the
// top level. Uses csma_pkg for the state codes.
module csma_mac_checker import csma_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [STATE_W-1:0] station_state_o,
  input logic               on_medium_o,
  input logic               frame_sent_o,
  input logic               frame_dropped_o,
  input logic [ATT_W-1:0]   attempt_count_o
);

  // A stalled result stays and holds its state, attempt count and sent flag
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(station_state_o)
      && $stable(attempt_count_o) && $stable(frame_sent_o))
    else $error("result changed under stall");

  // A frame ends either sent or dropped, never both
  a_end_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(frame_sent_o && frame_dropped_o))
    else $error("frame both sent and dropped");

  // Ending a frame returns to idle with the attempt count cleared
  a_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (frame_sent_o || frame_dropped_o)
      |-> station_state_o == SC_IDLE && attempt_count_o == '0)
    else $error("frame end without idle and cleared attempts");

  // On-medium flag tracks transmit and jam
  a_on_medium: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> on_medium_o == (station_state_o == SC_TX
      || station_state_o == SC_JAM))
    else $error("on_medium disagrees with station state");

endmodule

bind csma_cd_station_mac csma_mac_checker u_mac_checker (.*);
